// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 64;
    localparam int unsigned HEADER_BYTES   = 16;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned REQ_W          = 24;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REBUILD = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef enum logic {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } t_reg;

    // one block descriptor as held in a cell
    typedef struct packed {
        logic              vld;
        logic              used;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_ent;

    // search token walking down the row
    typedef struct packed {
        logic              active;
        logic              found;
        logic              split;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_pkt;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              rebuild;
        logic              shift;
        logic              alloc;
        logic [ADDR_W-1:0] key;
        logic              head_vld;
        logic [ADDR_W-1:0] head_addr;
        logic [ADDR_W-1:0] head_size;
    } t_ctl;

endpackage

// ===== rtl/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// One block descriptor slot; matches the passing search token and shifts
// toward the tail when a new block is put at the head.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_first,
    input  logic           i_can_split,
    input  ffba_pkg::t_ctl i_ctl,
    input  ffba_pkg::t_ent i_prev,
    output ffba_pkg::t_ent o_ent,
    input  ffba_pkg::t_pkt i_pkt,
    output ffba_pkg::t_pkt o_pkt
);
    import ffba_pkg::*;

    logic              r_vld;
    logic              r_used;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic              r_pkt_act;
    logic              r_pkt_found;
    logic              r_pkt_split;
    logic [ADDR_W-1:0] r_pkt_addr;
    logic [ADDR_W-1:0] r_pkt_size;

    logic hit_alloc;
    logic hit_free;
    logic take;
    logic split_ok;

    assign hit_alloc = r_vld && !r_used && (r_size >= i_ctl.key);
    assign hit_free  = r_vld && r_used
                       && ((r_addr + ADDR_W'(HEADER_BYTES)) == i_ctl.key);
    assign take      = i_pkt.active && !i_pkt.found
                       && (i_ctl.alloc ? hit_alloc : hit_free);
    assign split_ok  = i_can_split && ({1'b0, r_size} >=
                       ({1'b0, i_ctl.key} + (ADDR_W+1)'(2 * HEADER_BYTES)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_used    <= 1'b0;
            r_pkt_act <= 1'b0;
        end else begin
            r_pkt_act <= i_pkt.active;
            if (i_ctl.rebuild) begin
                r_vld  <= i_first && i_prev.vld;
                r_used <= 1'b0;
            end else if (i_ctl.shift) begin
                r_vld  <= i_prev.vld;
                r_used <= i_prev.used;
            end else if (take) begin
                r_used <= i_ctl.alloc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rebuild || i_ctl.shift) begin
            r_addr <= i_prev.addr;
            r_size <= i_prev.size;
        end else if (take && i_ctl.alloc && split_ok) begin
            r_size <= i_ctl.key;
        end
        r_pkt_found <= i_pkt.found || take;
        if (take) begin
            r_pkt_split <= i_ctl.alloc && split_ok;
            r_pkt_addr  <= r_addr;
            r_pkt_size  <= r_size;
        end else begin
            r_pkt_split <= i_pkt.split;
            r_pkt_addr  <= i_pkt.addr;
            r_pkt_size  <= i_pkt.size;
        end
    end

    assign o_ent = '{vld: r_vld, used: r_used, addr: r_addr, size: r_size};
    assign o_pkt = '{active: r_pkt_act, found: r_pkt_found, split: r_pkt_split,
                     addr: r_pkt_addr, size: r_pkt_size};

endmodule

// ===== rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Command sequencer: holds the heap registers, launches the search token,
// finishes splits and keeps the result register.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [ffba_pkg::REQ_W-1:0]    i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data,
    output ffba_pkg::t_ctl                o_ctl,
    output ffba_pkg::t_pkt                o_pkt,
    input  ffba_pkg::t_pkt                i_pkt
);
    import ffba_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state            r_state;
    logic              r_inj;
    logic              r_rebuild;
    logic              r_shift;
    logic              r_alloc;
    logic [ADDR_W-1:0] r_key;
    logic              r_head_vld;
    logic [ADDR_W-1:0] r_head_addr;
    logic [ADDR_W-1:0] r_head_size;
    logic [ADDR_W-1:0] r_heap_base;
    logic [ADDR_W-1:0] r_heap_bytes;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic                 accept;
    logic                 out_free;
    logic [REQ_W:0]       rounded;
    logic [ADDR_W-1:0]    total;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    // ((n >> 4) + 1) << 4
    assign rounded  = {({1'b0, i_request_size[REQ_W-1:4]} + (REQ_W-3)'(1)), 4'b0000};
    assign total    = {r_heap_bytes[ADDR_W-1:4], 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inj        <= 1'b0;
            r_rebuild    <= 1'b0;
            r_shift      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_heap_base  <= '0;
            r_heap_bytes <= '0;
        end else begin
            r_inj     <= accept && ((i_command == CMD_ALLOC) || (i_command == CMD_FREE));
            r_rebuild <= accept && (i_command == CMD_REBUILD);
            // the served block was already trimmed in its cell;
            // the remainder goes in at the head
            r_shift   <= (r_state == S_WALK) && i_pkt.active && i_pkt.found
                         && i_pkt.split;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                    REG_HEAP_BYTES: r_heap_bytes <= i_cfg_data;
                    default:        r_heap_base  <= r_heap_base;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_alloc      <= (i_command == CMD_ALLOC);
                        r_key        <= (i_command == CMD_ALLOC) ? ADDR_W'(rounded)
                                                                 : i_free_address;
                        r_res_addr   <= '0;
                        r_res_status <= ST_OK;
                        unique case (t_cmd'(i_command))
                            CMD_ALLOC, CMD_FREE: begin
                                r_state <= S_WALK;
                            end
                            CMD_REBUILD: begin
                                r_head_vld  <= |r_heap_bytes[ADDR_W-1:4];
                                r_head_addr <= r_heap_base;
                                r_head_size <= total - ADDR_W'(HEADER_BYTES);
                                r_state     <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (i_pkt.active) begin
                        if (!i_pkt.found) begin
                            r_res_status <= r_alloc ? ST_NOFIT : ST_BADFREE;
                        end else if (r_alloc) begin
                            r_res_addr <= i_pkt.addr + ADDR_W'(HEADER_BYTES);
                        end
                        if (i_pkt.found && i_pkt.split) begin
                            r_head_vld  <= 1'b1;
                            r_head_addr <= i_pkt.addr + ADDR_W'(HEADER_BYTES) + r_key;
                            r_head_size <= i_pkt.size - r_key
                                           - ADDR_W'(2 * HEADER_BYTES);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_addr   <= r_res_addr;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status          = r_out_status;
    assign o_cfg_ready       = 1'b1;

    assign o_ctl = '{rebuild: r_rebuild, shift: r_shift, alloc: r_alloc, key: r_key,
                     head_vld: r_head_vld, head_addr: r_head_addr,
                     head_size: r_head_size};
    assign o_pkt = '{active: r_inj, found: 1'b0, split: 1'b0,
                     addr: '0, size: '0};

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an ordered row of block descriptor cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   i_command, i_request_size,
//                                                 i_free_address
//  out       from block o_out_valid / i_out_stall o_granted_address, o_status
//  cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Allocate and free: a search token walks the cell row one cell per cycle, and
//  a split adds the head insert during the result cycle. Rebuild and unused
//  commands go straight from accept to the result step. One command is in
//  flight at a time. A held result stalls only the final step; the table
//  update is already done. Reset empties the table.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [ffba_pkg::REQ_W-1:0]    i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data
);
    import ffba_pkg::*;

    t_ctl ctl;
    t_ent head;
    t_ent ent [MAX_BLOCKS];
    t_pkt pkt [MAX_BLOCKS+1];
    logic can_split;

    ffba_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_ctl             (ctl),
        .o_pkt             (pkt[0]),
        .i_pkt             (pkt[MAX_BLOCKS])
    );

    // table full when the last slot holds a block
    assign can_split = !ent[MAX_BLOCKS-1].vld;
    assign head      = '{vld: ctl.head_vld, used: 1'b0,
                         addr: ctl.head_addr, size: ctl.head_size};

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_first     (g == 0),
            .i_can_split (can_split),
            .i_ctl       (ctl),
            .i_prev      ((g == 0) ? head : ent[(g == 0) ? 0 : g-1]),
            .o_ent       (ent[g]),
            .i_pkt       (pkt[g]),
            .o_pkt       (pkt[g+1])
        );
    end

endmodule

// ===== rtl/ffba_check.sv =====
// ----------------------------------------------------------------------------
// ffba_check
// Port-level checks for the first-fit block allocator, bound to the top.
// ----------------------------------------------------------------------------
module ffba_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_granted_address,
    input logic [1:0]  o_status
);
    import ffba_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted_address)
                                       && $stable(o_status))
        else $error("result changed while stalled");

    // one command at a time: an accepted transaction blocks the next cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOFIT || o_status == ST_BADFREE)
            |-> o_granted_address == '0)
        else $error("failed command returned an address");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != ST_RSVD)
        else $error("reserved status code");

endmodule

bind first_fit_block_allocator ffba_check u_ffba_check (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_granted_address (o_granted_address),
    .o_status          (o_status)
);

// ===== tb/ffba_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_scoreboard_pkg
// Block table predictor and result scoreboard for the first-fit allocator
// testbench.
// ----------------------------------------------------------------------------
package ffba_scoreboard_pkg;

    import ffba_pkg::*;

    typedef struct {
        bit [31:0] addr;
        t_status   status;
    } t_grant;

    class alloc_scoreboard;

        // shadow copy of the descriptor table and heap registers
        bit [31:0]   blk_addr [MAX_BLOCKS_DEF];
        bit [31:0]   blk_size [MAX_BLOCKS_DEF];
        bit          blk_used [MAX_BLOCKS_DEF];
        int unsigned blk_count;
        bit [31:0]   heap_base;
        bit [31:0]   heap_bytes;

        t_grant      expected_grants[$];
        int unsigned mismatches;

        function new();
            blk_count  = 0;
            heap_base  = '0;
            heap_bytes = '0;
            mismatches = 0;
            foreach (blk_used[i]) begin
                blk_addr[i] = '0;
                blk_size[i] = '0;
                blk_used[i] = 1'b0;
            end
        endfunction

        function void write_reg(t_reg idx, bit [31:0] data);
            if (idx == REG_HEAP_BASE) begin
                heap_base = data;
            end else begin
                heap_bytes = data;
            end
        endfunction

        function bit drained();
            return expected_grants.size() == 0;
        endfunction

        // payload address of a table entry; live_only restricts to in-use blocks
        function bit [31:0] pick_payload(bit live_only);
            int unsigned cand[$];
            for (int i = 0; i < blk_count; i++) begin
                if (!live_only || blk_used[i]) begin
                    cand.push_back(i);
                end
            end
            if (cand.size() == 0) begin
                return $urandom;
            end
            return blk_addr[cand[$urandom_range(cand.size() - 1)]] + HEADER_BYTES;
        endfunction

        // apply one accepted command to the shadow table, queue its result
        function void note_command(t_cmd cmd, bit [23:0] req, bit [31:0] payload);
            t_grant    g;
            bit [31:0] rounded;
            bit [31:0] base;
            bit [31:0] sz;
            bit [31:0] total;
            int        slot;
            bit        hit;

            g.addr   = '0;
            g.status = ST_OK;
            hit      = 1'b0;
            case (cmd)
                CMD_ALLOC: begin
                    rounded  = ((32'(req) >> 4) + 32'd1) << 4;
                    g.status = ST_NOFIT;
                    for (int i = 0; i < blk_count && !hit; i++) begin
                        if (!blk_used[i] && blk_size[i] >= rounded) begin
                            hit  = 1'b1;
                            base = blk_addr[i];
                            sz   = blk_size[i];
                            slot = i;
                            if (sz >= rounded + 2 * HEADER_BYTES &&
                                blk_count < MAX_BLOCKS_DEF) begin
                                blk_size[i] = rounded;
                                // remainder goes to the head, older entries move up
                                for (int k = blk_count; k > 0; k--) begin
                                    blk_addr[k] = blk_addr[k-1];
                                    blk_size[k] = blk_size[k-1];
                                    blk_used[k] = blk_used[k-1];
                                end
                                blk_addr[0] = base + HEADER_BYTES + rounded;
                                blk_size[0] = sz - rounded - 2 * HEADER_BYTES;
                                blk_used[0] = 1'b0;
                                blk_count++;
                                slot = i + 1;
                            end
                            blk_used[slot] = 1'b1;
                            g.addr   = base + HEADER_BYTES;
                            g.status = ST_OK;
                        end
                    end
                end
                CMD_FREE: begin
                    g.status = ST_BADFREE;
                    for (int i = 0; i < blk_count && !hit; i++) begin
                        if (blk_used[i] && blk_addr[i] + HEADER_BYTES == payload) begin
                            hit         = 1'b1;
                            blk_used[i] = 1'b0;
                            g.status    = ST_OK;
                        end
                    end
                end
                CMD_REBUILD: begin
                    total = heap_bytes & ~32'd15;
                    foreach (blk_used[i]) begin
                        blk_used[i] = 1'b0;
                    end
                    blk_count = 0;
                    if (total >= HEADER_BYTES) begin
                        blk_addr[0] = heap_base;
                        blk_size[0] = total - HEADER_BYTES;
                        blk_count   = 1;
                    end
                end
                default: ;
            endcase
            expected_grants.push_back(g);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [31:0] addr, logic [1:0] status);
            t_grant g;
            if (expected_grants.size() == 0) begin
                report($sformatf("result addr=%h status=%0d with no command outstanding",
                                 addr, status));
                return;
            end
            g = expected_grants.pop_front();
            if (addr !== g.addr) begin
                report($sformatf("granted_address %h, expected %h", addr, g.addr));
            end
            if (status !== g.status) begin
                report($sformatf("status %0d, expected %s", status, g.status.name()));
            end
        endtask

    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, rebuild and unused commands into the first-fit
// allocator under several heap settings and random flow control, and checks
// every result against a shadow descriptor table.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;
    import ffba_scoreboard_pkg::*;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command         = CMD_NOP;
    logic [23:0] i_request_size    = '0;
    logic [31:0] i_free_address    = '0;
    logic        o_out_valid;
    logic        i_out_stall       = 1'b0;
    logic [31:0] o_granted_address;
    logic [1:0]  o_status;
    logic        i_cfg_valid       = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index       = REG_HEAP_BASE;
    logic [31:0] i_cfg_data        = '0;

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 65;

    alloc_scoreboard sb = new();

    first_fit_block_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_granted_address, o_status);
        end
    end

    // one command transaction; valid stays high on return
    task issue_command(t_cmd cmd, logic [23:0] req, logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_request_size <= req;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_command(cmd, req, addr);
    endtask

    task wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (!sb.drained());
    endtask

    // both registers back to back; block must be idle
    task program_heap(logic [31:0] base, logic [31:0] bytes);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_HEAP_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(REG_HEAP_BASE, base);
        i_cfg_index <= REG_HEAP_BYTES;
        i_cfg_data  <= bytes;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(REG_HEAP_BYTES, bytes);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly alloc/free of live blocks, some double frees, junk and rebuilds
    task run_random(logic [31:0] base, logic [31:0] bytes, int unsigned req_max,
                    int unsigned n);
        int unsigned pick;
        logic [23:0] req;
        program_heap(base, bytes);
        issue_command(CMD_REBUILD, 24'($urandom), $urandom);
        for (int k = 1; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                issue_command(CMD_REBUILD, 24'($urandom), $urandom);
            end else if (pick < 4) begin
                issue_command(CMD_NOP, 24'($urandom), $urandom);
            end else if (pick < 55) begin
                case ($urandom_range(19))
                    0:       req = 24'($urandom);
                    1, 2:    req = 24'($urandom_range(47));
                    default: req = 24'($urandom_range(req_max));
                endcase
                issue_command(CMD_ALLOC, req, $urandom);
            end else if (pick < 85) begin
                issue_command(CMD_FREE, 24'($urandom), sb.pick_payload(1'b1));
            end else if (pick < 92) begin
                issue_command(CMD_FREE, 24'($urandom), sb.pick_payload(1'b0));
            end else if (pick < 94) begin
                issue_command(CMD_FREE, 24'($urandom), '0);
            end else begin
                issue_command(CMD_FREE, 24'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table straight out of reset
        issue_command(CMD_ALLOC, '0, 32'hFFFF_FFFF);
        issue_command(CMD_FREE, 24'hFFFFFF, '0);
        issue_command(CMD_REBUILD, '0, '0);
        issue_command(CMD_ALLOC, 24'h000010, '0);
        issue_command(CMD_NOP, 24'hFFFFFF, 32'hFFFF_FFFF);

        // heap smaller than one header
        program_heap(32'h0000_0000, 32'h0000_000F);
        issue_command(CMD_REBUILD, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);

        // single block with zero payload
        program_heap(32'h0000_0100, 32'h0000_0010);
        issue_command(CMD_REBUILD, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);

        // heap wrapping past the top of the address space
        program_heap(32'hFFFF_FFF0, 32'h0000_007F);
        issue_command(CMD_REBUILD, '0, '0);
        issue_command(CMD_ALLOC, 24'h00000F, '0);
        issue_command(CMD_FREE, '0, 32'h0000_0000);
        issue_command(CMD_FREE, '0, 32'h0000_0000);
        issue_command(CMD_ALLOC, 24'h000010, '0);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, '0, 32'h0000_0020);
        issue_command(CMD_FREE, '0, 32'h1234_5678);

        // largest heap, largest requests
        program_heap(32'h0000_4000, 32'hFFFF_FFFF);
        issue_command(CMD_REBUILD, '0, '0);
        issue_command(CMD_ALLOC, 24'hFFFFFF, '0);
        issue_command(CMD_ALLOC, 24'hFFFFFF, '0);
        issue_command(CMD_ALLOC, 24'h00000F, '0);
        issue_command(CMD_FREE, '0, sb.pick_payload(1'b1));

        run_random(32'h0000_1000, 32'h0001_0000, 300, 500);

        send_idle_pct = 65;
        recv_idle_pct = 12;
        run_random(32'hFFFF_F800, 32'h0000_4007, 200, 450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 350);
        run_random(32'h0000_0000, 32'h0000_0120, 64, 350);

        wait_drain();
        repeat (2 * MAX_BLOCKS_DEF) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("first_fit_block_allocator test passed");
        end else begin
            $display("first_fit_block_allocator test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("first_fit_block_allocator test failed");
        $finish;
    end

endmodule
